### rtl/adshr_pkg.sv
// ---------------------------------------------------------------------------
// adshr_pkg
// Shared types, register codes and constants of the envelope evaluator.
// ---------------------------------------------------------------------------
package adshr_pkg;

    localparam int TIME_W  = 32;              // Q16.16 time and durations
    localparam int LEVEL_W = 24;              // signed Q8.16 levels
    localparam int PHASE_W = 3;
    localparam int FRAC_W  = 16;
    localparam int QUO_W   = FRAC_W + 1;      // alpha runs from 0 to 65536 in a sloped phase
    localparam int REM_W   = TIME_W + 1;
    localparam int DIFF_W  = LEVEL_W + 1;
    localparam int PROD_W  = DIFF_W + QUO_W + 1;
    localparam int SUM2_W  = TIME_W + 1;
    localparam int SUM4_W  = TIME_W + 2;
    localparam int IDX_W   = 3;

    typedef enum logic [IDX_W-1:0] {
        CFG_BASE_LEVEL    = 3'd0,
        CFG_PEAK_LEVEL    = 3'd1,
        CFG_ATTACK_TIME   = 3'd2,
        CFG_DECAY_TIME    = 3'd3,
        CFG_SUSTAIN_LEVEL = 3'd4,
        CFG_HOLD_TIME     = 3'd5,
        CFG_RELEASE_TIME  = 3'd6
    } t_cfg_idx;

    localparam logic [PHASE_W-1:0] PH_OUTSIDE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HOLD    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

    localparam logic [LEVEL_W-1:0] RST_BASE_LEVEL    = 24'd0;
    localparam logic [LEVEL_W-1:0] RST_PEAK_LEVEL    = 24'd65536;
    localparam logic [TIME_W-1:0]  RST_ATTACK_TIME   = 32'd65536;
    localparam logic [TIME_W-1:0]  RST_DECAY_TIME    = 32'd0;
    localparam logic [LEVEL_W-1:0] RST_SUSTAIN_LEVEL = 24'd65536;
    localparam logic [TIME_W-1:0]  RST_HOLD_TIME     = 32'd65536;
    localparam logic [TIME_W-1:0]  RST_RELEASE_TIME  = 32'd65536;

    // Programmed values plus the running phase end times.
    typedef struct packed {
        logic [LEVEL_W-1:0] base_level;
        logic [LEVEL_W-1:0] peak_level;
        logic [LEVEL_W-1:0] sustain_level;
        logic [TIME_W-1:0]  attack_time;
        logic [TIME_W-1:0]  decay_time;
        logic [TIME_W-1:0]  release_time;
        logic [SUM2_W-1:0]  end_decay;
        logic [SUM4_W-1:0]  end_hold;
        logic [SUM4_W-1:0]  total;
    } t_cfg;

    // What one division cell hands to its neighbor.
    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [TIME_W-1:0]  len;
        logic [QUO_W-1:0]   quo;
        logic [LEVEL_W-1:0] a;
        logic [LEVEL_W-1:0] b;
        logic [PHASE_W-1:0] phase;
    } t_cell;

endpackage

### rtl/adshr_cfg.sv
// ---------------------------------------------------------------------------
// adshr_cfg
// Envelope registers and the cumulative phase end times derived from them.
// ---------------------------------------------------------------------------
module adshr_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [adshr_pkg::IDX_W-1:0]      i_wr_index,
    input  logic [adshr_pkg::TIME_W-1:0]     i_wr_data,
    output adshr_pkg::t_cfg                  o_cfg
);

    logic [adshr_pkg::LEVEL_W-1:0] r_base_level;
    logic [adshr_pkg::LEVEL_W-1:0] r_peak_level;
    logic [adshr_pkg::LEVEL_W-1:0] r_sustain_level;
    logic [adshr_pkg::TIME_W-1:0]  r_attack_time;
    logic [adshr_pkg::TIME_W-1:0]  r_decay_time;
    logic [adshr_pkg::TIME_W-1:0]  r_hold_time;
    logic [adshr_pkg::TIME_W-1:0]  r_release_time;
    logic [adshr_pkg::SUM2_W-1:0]  r_end_decay;
    logic [adshr_pkg::SUM4_W-1:0]  r_end_hold;
    logic [adshr_pkg::SUM4_W-1:0]  r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_level    <= adshr_pkg::RST_BASE_LEVEL;
            r_peak_level    <= adshr_pkg::RST_PEAK_LEVEL;
            r_sustain_level <= adshr_pkg::RST_SUSTAIN_LEVEL;
            r_attack_time   <= adshr_pkg::RST_ATTACK_TIME;
            r_decay_time    <= adshr_pkg::RST_DECAY_TIME;
            r_hold_time     <= adshr_pkg::RST_HOLD_TIME;
            r_release_time  <= adshr_pkg::RST_RELEASE_TIME;
        end else if (i_wr_en) begin
            case (adshr_pkg::t_cfg_idx'(i_wr_index))
                adshr_pkg::CFG_BASE_LEVEL: begin
                    r_base_level <= i_wr_data[adshr_pkg::LEVEL_W-1:0];
                end
                adshr_pkg::CFG_PEAK_LEVEL: begin
                    r_peak_level <= i_wr_data[adshr_pkg::LEVEL_W-1:0];
                end
                adshr_pkg::CFG_ATTACK_TIME: begin
                    r_attack_time <= i_wr_data;
                end
                adshr_pkg::CFG_DECAY_TIME: begin
                    r_decay_time <= i_wr_data;
                end
                adshr_pkg::CFG_SUSTAIN_LEVEL: begin
                    r_sustain_level <= i_wr_data[adshr_pkg::LEVEL_W-1:0];
                end
                adshr_pkg::CFG_HOLD_TIME: begin
                    r_hold_time <= i_wr_data;
                end
                adshr_pkg::CFG_RELEASE_TIME: begin
                    r_release_time <= i_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    // The end times are registered sums of the registers above, so they change
    // after those do. A beat likewise passes the input register before it is compared.
    always_ff @(posedge i_clk) begin
        r_end_decay <= {1'b0, r_attack_time} + {1'b0, r_decay_time};
        r_end_hold  <= {2'b0, r_attack_time} + {2'b0, r_decay_time}
                     + {2'b0, r_hold_time};
        r_total     <= {2'b0, r_attack_time} + {2'b0, r_decay_time}
                     + {2'b0, r_hold_time} + {2'b0, r_release_time};
    end

    always_comb begin
        o_cfg.base_level    = r_base_level;
        o_cfg.peak_level    = r_peak_level;
        o_cfg.sustain_level = r_sustain_level;
        o_cfg.attack_time   = r_attack_time;
        o_cfg.decay_time    = r_decay_time;
        o_cfg.release_time  = r_release_time;
        o_cfg.end_decay     = r_end_decay;
        o_cfg.end_hold      = r_end_hold;
        o_cfg.total         = r_total;
    end

endmodule

### rtl/adshr_div_cell.sv
// ---------------------------------------------------------------------------
// adshr_div_cell
// One restoring division step: decides one bit of alpha and passes the
// partial remainder on to the next cell.
// ---------------------------------------------------------------------------
module adshr_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  adshr_pkg::t_cell    i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output adshr_pkg::t_cell    o_data
);

    logic                              r_valid;
    adshr_pkg::t_cell                  r_data;
    adshr_pkg::t_cell                  n_data;
    logic                              w_ge;
    logic [adshr_pkg::REM_W-1:0]       w_diff;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_ge   = i_data.rem >= {1'b0, i_data.len};
        w_diff = w_ge ? (i_data.rem - {1'b0, i_data.len}) : i_data.rem;
        n_data = i_data;
        // The remainder is below len here, so it fits in TIME_W bits.
        n_data.rem = {w_diff[adshr_pkg::TIME_W-1:0], 1'b0};
        n_data.quo = {i_data.quo[adshr_pkg::QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/adshr_scale.sv
// ---------------------------------------------------------------------------
// adshr_scale
// Interpolation back end: multiplies (b - a) by alpha, then adds a.
// ---------------------------------------------------------------------------
module adshr_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  adshr_pkg::t_cell                    i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [adshr_pkg::LEVEL_W-1:0]       o_level,
    output logic [adshr_pkg::PHASE_W-1:0]       o_phase
);

    logic                                   r_mul_valid;
    logic signed [adshr_pkg::PROD_W-1:0]    r_prod;
    logic [adshr_pkg::LEVEL_W-1:0]          r_mul_a;
    logic [adshr_pkg::PHASE_W-1:0]          r_mul_phase;
    logic                                   r_out_valid;
    logic [adshr_pkg::LEVEL_W-1:0]          r_level;
    logic [adshr_pkg::PHASE_W-1:0]          r_phase;
    logic                                   w_mul_ready;
    logic                                   w_out_ready;
    logic signed [adshr_pkg::DIFF_W-1:0]    w_diff;
    logic signed [adshr_pkg::QUO_W:0]       w_alpha;

    assign w_out_ready = !r_out_valid || i_ready;
    assign w_mul_ready = !r_mul_valid || w_out_ready;
    assign o_ready     = w_mul_ready;

    assign w_diff  = $signed({i_data.b[adshr_pkg::LEVEL_W-1], i_data.b})
                   - $signed({i_data.a[adshr_pkg::LEVEL_W-1], i_data.a});
    assign w_alpha = $signed({1'b0, i_data.quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_mul_ready) begin
                r_mul_valid <= i_valid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_mul_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_ready && i_valid) begin
            r_prod      <= adshr_pkg::PROD_W'(w_diff * w_alpha);
            r_mul_a     <= i_data.a;
            r_mul_phase <= i_data.phase;
        end
        // The bits above FRAC_W are floor(prod / 2^16); only the low
        // LEVEL_W bits of the sum survive.
        if (w_out_ready && r_mul_valid) begin
            r_level <= r_mul_a
                     + r_prod[adshr_pkg::FRAC_W +: adshr_pkg::LEVEL_W];
            r_phase <= r_mul_phase;
        end
    end

    assign o_valid = r_out_valid;
    assign o_level = r_level;
    assign o_phase = r_phase;

endmodule

### rtl/adshr_envelope_evaluator_unit.sv
// ---------------------------------------------------------------------------
// adshr_envelope_evaluator_unit
// Attack, decay, hold and release envelope evaluated at a given time.
// ---------------------------------------------------------------------------
// Each beat on the s_axis side carries one signed Q16.16 time. The block
// answers with one beat on the m_axis side: the envelope level (signed
// Q8.16) and the phase the time falls in. Envelope registers are written
// through the cfg channel (index, data); o_cfg_ready is always high, and
// registers may only change while no beat is in flight.
// A beat passes an input register, phase selection, a row of 17 division
// cells that produce the 17-bit interpolation fraction one bit per cell,
// a multiply stage and the output register. A new time is taken every
// cycle while the receiver keeps up; each division cell is its own stage.
// Every stage holds its beat while the next one is full, so a stalled
// receiver fills the pipeline bubble by bubble before s_axis_tready falls.
// Reset empties the pipeline and loads the default envelope.
// ---------------------------------------------------------------------------
module adshr_envelope_evaluator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [adshr_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [adshr_pkg::TIME_W-1:0]        i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,  // [31:0] sample_time
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata   // [23:0] level,
                                                               // [26:24] phase
);

    localparam int NCELL = adshr_pkg::QUO_W;

    adshr_pkg::t_cfg                    w_cfg;
    logic                               r_in_valid;
    logic [adshr_pkg::TIME_W-1:0]       r_raw;
    logic                               r_sel_valid;
    adshr_pkg::t_cell                   r_sel;
    adshr_pkg::t_cell                   n_sel;
    logic                               w_sel_ready;
    logic                               w_outside;
    logic                               w_in_attack;
    logic                               w_in_decay;
    logic                               w_in_hold;
    adshr_pkg::t_cell                   w_cell_data [0:NCELL];
    logic                               w_cell_valid [0:NCELL];
    logic                               w_cell_ready [0:NCELL];
    logic [adshr_pkg::LEVEL_W-1:0]      w_level;
    logic [adshr_pkg::PHASE_W-1:0]      w_phase;

    assign o_cfg_ready = 1'b1;

    adshr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Input register.
    assign s_axis_tready = !r_in_valid || w_sel_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_raw <= s_axis_tdata;
        end
    end

    // Phase selection: offset into the phase, its length and the two end
    // levels. Flat stretches get a == b so the fraction does not matter.
    always_comb begin
        w_outside   = r_raw[adshr_pkg::TIME_W-1]
                   || ({2'b0, r_raw} > w_cfg.total);
        w_in_attack = r_raw < w_cfg.attack_time;
        w_in_decay  = {1'b0, r_raw} < w_cfg.end_decay;
        w_in_hold   = {2'b0, r_raw} < w_cfg.end_hold;

        n_sel.quo = '0;
        n_sel.rem = '0;
        n_sel.len = w_cfg.release_time;
        n_sel.a   = w_cfg.base_level;
        n_sel.b   = w_cfg.base_level;
        if (w_outside) begin
            n_sel.phase = adshr_pkg::PH_OUTSIDE;
        end else if (w_in_attack) begin
            n_sel.phase = adshr_pkg::PH_ATTACK;
            n_sel.rem   = {1'b0, r_raw};
            n_sel.len   = w_cfg.attack_time;
            n_sel.b     = w_cfg.peak_level;
        end else if (w_in_decay) begin
            n_sel.phase = adshr_pkg::PH_DECAY;
            n_sel.rem   = {1'b0, r_raw - w_cfg.attack_time};
            n_sel.len   = w_cfg.decay_time;
            n_sel.a     = w_cfg.peak_level;
            n_sel.b     = w_cfg.sustain_level;
        end else if (w_in_hold) begin
            n_sel.phase = adshr_pkg::PH_HOLD;
            n_sel.a     = w_cfg.sustain_level;
            n_sel.b     = w_cfg.sustain_level;
        end else begin
            // The end of hold lies below 2^31 here, so 32 bits suffice.
            n_sel.phase = adshr_pkg::PH_RELEASE;
            n_sel.rem   = {1'b0, r_raw - w_cfg.end_hold[adshr_pkg::TIME_W-1:0]};
            if (w_cfg.release_time != '0) begin
                n_sel.a = w_cfg.sustain_level;
            end
        end
    end

    assign w_sel_ready = !r_sel_valid || w_cell_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_valid <= 1'b0;
        end else if (w_sel_ready) begin
            r_sel_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel_ready && r_in_valid) begin
            r_sel <= n_sel;
        end
    end

    assign w_cell_data[0]  = r_sel;
    assign w_cell_valid[0] = r_sel_valid;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        adshr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cell_valid[g]),
            .o_ready (w_cell_ready[g]),
            .i_data  (w_cell_data[g]),
            .o_valid (w_cell_valid[g+1]),
            .i_ready (w_cell_ready[g+1]),
            .o_data  (w_cell_data[g+1])
        );
    end

    adshr_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cell_valid[NCELL]),
        .o_ready (w_cell_ready[NCELL]),
        .i_data  (w_cell_data[NCELL]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_level (w_level),
        .o_phase (w_phase)
    );

    assign m_axis_tdata = {5'b0, w_phase, w_level};

endmodule
